@@ hdl/tcgcs_pkg.sv @@
// Shared types and constants for the text cursor glyph command sequencer.
package tcgcs_pkg;

  // Field widths
  localparam int unsigned CODE_W = 8;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned PAGE_W = 3;

  // Default geometry
  localparam int unsigned DISPLAY_COLUMNS = 102;
  localparam int unsigned GLYPH_WIDTH     = 6;
  localparam int unsigned PAGE_COUNT      = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Operation codes
  localparam logic OP_PUT_CHAR     = 1'b0;
  localparam logic OP_RESET_CURSOR = 1'b1;

  // Control characters and printable range
  localparam logic [CODE_W-1:0] CHAR_TAB        = 8'h09;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_RETURN     = 8'h0D;
  localparam logic [CODE_W-1:0] CHAR_FIRST      = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_END        = 8'h80;
  localparam logic [CODE_W-1:0] CHAR_SUBSTITUTE = 8'h3F;

  // Controller command bases
  localparam logic [CMD_W-1:0] CMD_PAGE_BASE     = 8'hB0;
  localparam logic [CMD_W-1:0] CMD_COL_HIGH_BASE = 8'h10;

  // One glyph to draw, handed from the front to the back
  typedef struct packed {
    logic [CMD_W-1:0]  page_cmd;
    logic [COL_W-1:0]  column;
    logic [ADDR_W-1:0] base;
  } job_t;

  // Item within one glyph column
  typedef enum logic [1:0] {
    PH_PAGE   = 2'd0,
    PH_COL_LO = 2'd1,
    PH_COL_HI = 2'd2,
    PH_DATA   = 2'd3
  } phase_e;

endpackage

@@ hdl/text_cursor_glyph_command_sequencer.sv @@
// Top level of the text cursor glyph command sequencer.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | operation_i, char_code_i
//   out     | output    | out_valid_o/out_stall_i | is_data_o, command_byte_o,
//           |           |                      | font_address_o, last_o
//
// A printable character yields 4*GlyphWidth items (24 by default), one per
// cycle from the back end's output register while out_stall_i is low; the back
// end sets the rate. Cursor moves, tabs, newlines and returns yield no items.
// Requests are taken while the job queue has room, so the front end keeps
// accepting while the back end drains; out_stall_i freezes only the back end.
// Reset clears the cursor to page 0 column 0 and empties the queue.
module text_cursor_glyph_command_sequencer
  import tcgcs_pkg::*;
#(
  parameter int unsigned DisplayColumns = DISPLAY_COLUMNS,
  parameter int unsigned GlyphWidth     = GLYPH_WIDTH,
  parameter int unsigned PageCount      = PAGE_COUNT,
  parameter int unsigned QueueDepth     = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [CODE_W-1:0] char_code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              is_data_o,
  output logic [CMD_W-1:0]  command_byte_o,
  output logic [ADDR_W-1:0] font_address_o,
  output logic              last_o
);

  logic job_push, job_full, job_pop, job_valid;
  job_t job_in, job_out;

  tcgcs_front #(
    .DisplayColumns(DisplayColumns),
    .GlyphWidth    (GlyphWidth),
    .PageCount     (PageCount)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .char_code_i(char_code_i),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  tcgcs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .data_o (job_out)
  );

  tcgcs_back #(
    .GlyphWidth(GlyphWidth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_out),
    .job_pop_o     (job_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_data_o     (is_data_o),
    .command_byte_o(command_byte_o),
    .font_address_o(font_address_o),
    .last_o        (last_o)
  );

endmodule

@@ hdl/tcgcs_front.sv @@
// Front end: accepts requests, keeps the text cursor and queues glyph jobs.
module tcgcs_front
  import tcgcs_pkg::*;
#(
  parameter int unsigned DisplayColumns = DISPLAY_COLUMNS,
  parameter int unsigned GlyphWidth     = GLYPH_WIDTH,
  parameter int unsigned PageCount      = PAGE_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [CODE_W-1:0] char_code_i,
  input  logic              job_full_i,
  output logic              job_push_o,
  output job_t              job_o
);

  localparam logic [COL_W:0]    ColLimit  = (COL_W+1)'(DisplayColumns);
  localparam logic [COL_W:0]    TabStep   = (COL_W+1)'(2 * GlyphWidth);
  localparam logic [COL_W:0]    GlyphStep = (COL_W+1)'(GlyphWidth);
  localparam logic [PAGE_W-1:0] PageLast  = PAGE_W'(PageCount - 1);
  localparam logic [CMD_W-1:0]  PageTop   = CMD_PAGE_BASE + CMD_W'(PageCount - 1);
  localparam logic [ADDR_W-1:0] GwAddr    = ADDR_W'(GlyphWidth);

  logic [COL_W-1:0]  col_q, col_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic              accept;
  logic              is_glyph;
  logic [CODE_W-1:0] glyph_code;
  logic [COL_W:0]    col_sum;
  logic              col_wrap;
  logic [PAGE_W-1:0] page_inc;

  assign in_stall_o = job_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the character
  assign is_glyph   = (char_code_i != CHAR_TAB) && (char_code_i != CHAR_NEWLINE) &&
                      (char_code_i != CHAR_RETURN);
  assign glyph_code = (char_code_i >= CHAR_FIRST && char_code_i < CHAR_END) ?
                      char_code_i : CHAR_SUBSTITUTE;

  // Advance the column by a tab or a glyph, wrapping at the display edge
  assign col_sum  = {1'b0, col_q} + ((char_code_i == CHAR_TAB) ? TabStep : GlyphStep);
  assign col_wrap = col_sum >= ColLimit;
  assign page_inc = (page_q == PageLast) ? '0 : page_q + 1'b1;

  // Cursor update
  always_comb begin
    col_d  = col_q;
    page_d = page_q;
    if (accept) begin
      if (operation_i == OP_RESET_CURSOR) begin
        col_d  = '0;
        page_d = '0;
      end else if (char_code_i == CHAR_NEWLINE) begin
        page_d = page_inc;
      end else if (char_code_i == CHAR_RETURN) begin
        col_d = '0;
      end else if (col_wrap) begin
        col_d  = '0;
        page_d = page_inc;
      end else begin
        col_d = col_sum[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      page_q <= '0;
    end else begin
      col_q  <= col_d;
      page_q <= page_d;
    end
  end

  // Queue a glyph job with the cursor as it stands before the advance
  assign job_push_o     = accept && (operation_i == OP_PUT_CHAR) && is_glyph;
  assign job_o.page_cmd = PageTop - {{(CMD_W-PAGE_W){1'b0}}, page_q};
  assign job_o.column   = col_q;
  assign job_o.base     = GwAddr * ADDR_W'(glyph_code - CHAR_FIRST);

endmodule

@@ hdl/tcgcs_queue.sv @@
// Small job queue between the front and the back.
module tcgcs_queue
  import tcgcs_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntFull;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/tcgcs_back.sv @@
// Back end: walks one glyph job and emits command and data items.
module tcgcs_back
  import tcgcs_pkg::*;
#(
  parameter int unsigned GlyphWidth = GLYPH_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              is_data_o,
  output logic [CMD_W-1:0]  command_byte_o,
  output logic [ADDR_W-1:0] font_address_o,
  output logic              last_o
);

  localparam int unsigned IdxW = $clog2(GlyphWidth);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(GlyphWidth - 1);

  job_t              job_q, job_d;
  logic              act_q, act_d;
  phase_e            phase_q, phase_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              out_valid_q;
  logic              is_data_q, last_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic              load, emit, final_item, job_take;
  logic [COL_W:0]    cur_col;
  logic              item_is_data, item_last;
  logic [CMD_W-1:0]  item_cmd;
  logic [ADDR_W-1:0] item_addr;

  assign load       = !out_valid_q || !out_stall_i;
  assign emit       = act_q && load;
  assign final_item = (phase_q == PH_DATA) && (idx_q == IdxLast);
  assign job_take   = job_valid_i && (!act_q || (emit && final_item));
  assign job_pop_o  = job_take;

  // Next step within the job
  always_comb begin
    job_d   = job_q;
    act_d   = act_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    if (job_take) begin
      job_d   = job_i;
      act_d   = 1'b1;
      phase_d = PH_PAGE;
      idx_d   = '0;
    end else if (emit) begin
      if (final_item) begin
        act_d = 1'b0;
      end
      case (phase_q)
        PH_PAGE:   phase_d = PH_COL_LO;
        PH_COL_LO: phase_d = PH_COL_HI;
        PH_COL_HI: phase_d = PH_DATA;
        PH_DATA: begin
          phase_d = PH_PAGE;
          idx_d   = idx_q + 1'b1;
        end
        default:   phase_d = PH_PAGE;
      endcase
    end
  end

  // Build the current item
  assign cur_col = {1'b0, job_q.column} + (COL_W+1)'(idx_q);

  always_comb begin
    item_is_data = 1'b0;
    item_cmd     = '0;
    item_addr    = '0;
    item_last    = 1'b0;
    case (phase_q)
      PH_PAGE:   item_cmd = job_q.page_cmd;
      PH_COL_LO: item_cmd = {4'h0, cur_col[3:0]};
      PH_COL_HI: item_cmd = {4'h0, cur_col[7:4]} + CMD_COL_HIGH_BASE;
      PH_DATA: begin
        item_is_data = 1'b1;
        item_addr    = job_q.base + ADDR_W'(idx_q);
        item_last    = idx_q == IdxLast;
      end
      default:   item_cmd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      phase_q     <= PH_PAGE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= act_q;
      end
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      is_data_q <= item_is_data;
      cmd_q     <= item_cmd;
      addr_q    <= item_addr;
      last_q    <= item_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_data_o      = is_data_q;
  assign command_byte_o = cmd_q;
  assign font_address_o = addr_q;
  assign last_o         = last_q;

endmodule

@@ hdl/tcgcs_checker.sv @@
// Port-level checks for the text cursor glyph command sequencer.
module tcgcs_checker
  import tcgcs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              operation_i,
  input logic [CODE_W-1:0] char_code_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              is_data_o,
  input logic [CMD_W-1:0]  command_byte_o,
  input logic [ADDR_W-1:0] font_address_o,
  input logic              last_o
);

  logic out_take;
  assign out_take = out_valid_o && !out_stall_i;

  // Hold a stalled request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(operation_i) && $stable(char_code_i)))
    else $error("stalled request changed");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(command_byte_o) && $stable(font_address_o) &&
       $stable(is_data_o) && $stable(last_o)))
    else $error("stalled result changed");

  // A glyph column that is not the last is followed at once by a page command
  a_next_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && is_data_o && !last_o) |=>
      (out_valid_o && !is_data_o && command_byte_o[7:4] == CMD_PAGE_BASE[7:4]))
    else $error("page command missing after glyph column");

  // A page command is followed at once by the column low nibble
  a_next_col_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !is_data_o && command_byte_o[7:4] == CMD_PAGE_BASE[7:4]) |=>
      (out_valid_o && !is_data_o && command_byte_o[7:4] == 4'h0))
    else $error("column low command missing after page command");

endmodule

bind text_cursor_glyph_command_sequencer tcgcs_checker u_tcgcs_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the text cursor glyph command sequencer.
`timescale 1ns / 1ps

module tb;
  import tcgcs_pkg::*;

  typedef struct {
    logic              operation;
    logic [CODE_W-1:0] code;
  } text_request_t;

  typedef struct {
    logic              is_data;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic              last;
  } lcd_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              operation_i = OP_PUT_CHAR;
  logic [CODE_W-1:0] char_code_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              is_data_o;
  logic [CMD_W-1:0]  command_byte_o;
  logic [ADDR_W-1:0] font_address_o;
  logic              last_o;

  text_request_t pending_text[$];
  lcd_beat_t     lcd_beats_due[$];

  // Cursor as the block should hold it
  logic [COL_W-1:0]  cursor_col = '0;
  logic [PAGE_W-1:0] cursor_page = '0;

  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned glyphs_drawn = 0;
  int unsigned cursor_resets = 0;
  int unsigned line_wraps = 0;
  int unsigned beats_checked = 0;

  text_cursor_glyph_command_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_data_o      (is_data_o),
    .command_byte_o (command_byte_o),
    .font_address_o (font_address_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) idle_length = 0;
    else if (r < 85) idle_length = $urandom_range(1, 3);
    else if (r < 97) idle_length = $urandom_range(4, 12);
    else idle_length = $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_text(input logic op, input logic [CODE_W-1:0] code);
    text_request_t req;
    req.operation = op;
    req.code = code;
    pending_text.push_back(req);
  endtask

  // Advance the cursor for one request and queue the command/data beats it draws
  task automatic draw_text(input logic op, input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] glyph;
    logic [ADDR_W-1:0] base;
    logic [CMD_W-1:0]  page_cmd;
    int unsigned       next_col;
    int unsigned       next_page;
    int unsigned       c;
    lcd_beat_t         beat;
    next_col = cursor_col;
    next_page = cursor_page;
    if (op == OP_RESET_CURSOR) begin
      next_col = 0;
      next_page = 0;
      cursor_resets++;
    end else if (code == CHAR_NEWLINE) begin
      next_page++;
    end else if (code == CHAR_TAB) begin
      next_col += 2 * GLYPH_WIDTH;
      if (next_col >= DISPLAY_COLUMNS) begin
        next_col = 0;
        next_page++;
        line_wraps++;
      end
    end else if (code == CHAR_RETURN) begin
      next_col = 0;
    end else begin
      // Draw anything outside the printable range as a question mark
      glyph = (code < CHAR_FIRST || code >= CHAR_END) ? CHAR_SUBSTITUTE : code;
      base = ADDR_W'(GLYPH_WIDTH * (glyph - CHAR_FIRST));
      page_cmd = CMD_PAGE_BASE + CMD_W'(PAGE_COUNT - 1 - cursor_page);
      for (int unsigned i = 0; i < GLYPH_WIDTH; i++) begin
        c = cursor_col + i;
        beat = '{is_data: 1'b0, command: page_cmd, address: '0, last: 1'b0};
        lcd_beats_due.push_back(beat);
        beat.command = CMD_W'(c & 'hF);
        lcd_beats_due.push_back(beat);
        beat.command = CMD_W'(c >> 4) + CMD_COL_HIGH_BASE;
        lcd_beats_due.push_back(beat);
        beat = '{is_data: 1'b1, command: '0, address: base + ADDR_W'(i),
                 last: (i == GLYPH_WIDTH - 1)};
        lcd_beats_due.push_back(beat);
      end
      next_col += GLYPH_WIDTH;
      if (next_col >= DISPLAY_COLUMNS) begin
        next_col = 0;
        next_page++;
        line_wraps++;
      end
      glyphs_drawn++;
    end
    if (next_page >= PAGE_COUNT) next_page = 0;
    cursor_col = COL_W'(next_col);
    cursor_page = PAGE_W'(next_page);
  endtask

  // Request driver: hold each request until taken, then idle for a random gap
  int unsigned send_gap = 0;
  int unsigned send_burst = 0;
  text_request_t next_req;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        requests_taken++;
        draw_text(operation_i, char_code_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (pending_text.size() > 0) begin
          next_req = pending_text.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= next_req.operation;
          char_code_i <= next_req.code;
          if (send_burst > 0) begin
            send_burst--;
            send_gap = 0;
          end else if ($urandom_range(0, 99) < 8) begin
            send_burst = $urandom_range(20, 60);
            send_gap = 0;
          end else begin
            send_gap = idle_length();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each beat taken, then pick the next stall pattern
  int unsigned stall_left = 0;
  int unsigned flow_left = 0;
  lcd_beat_t   due;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (lcd_beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data=%0b cmd=%02h addr=%0d last=%0b",
                                    is_data_o, command_byte_o, font_address_o, last_o));
        end else begin
          due = lcd_beats_due.pop_front();
          beats_checked++;
          if (is_data_o !== due.is_data)
            report_mismatch($sformatf("is_data %0b, want %0b", is_data_o, due.is_data));
          if (command_byte_o !== due.command)
            report_mismatch($sformatf("command_byte %02h, want %02h",
                                      command_byte_o, due.command));
          if (font_address_o !== due.address)
            report_mismatch($sformatf("font_address %0d, want %0d",
                                      font_address_o, due.address));
          if (last_o !== due.last)
            report_mismatch($sformatf("last %0b, want %0b", last_o, due.last));
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (flow_left > 0) begin
        out_stall_i <= 1'b0;
        flow_left--;
      end else begin
        out_stall_i <= 1'b0;
        flow_left = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 150)
                                                 : $urandom_range(0, 9);
        stall_left = idle_length();
      end
    end
  end

  initial begin
    int unsigned r;
    // Directed: printable edges, substitutes, control codes, page wrap
    queue_text(OP_RESET_CURSOR, 8'hFF);
    queue_text(OP_PUT_CHAR, CHAR_FIRST);
    queue_text(OP_PUT_CHAR, 8'h7F);
    queue_text(OP_PUT_CHAR, CHAR_END);
    queue_text(OP_PUT_CHAR, 8'hFF);
    queue_text(OP_PUT_CHAR, 8'h00);
    queue_text(OP_PUT_CHAR, 8'h1F);
    queue_text(OP_PUT_CHAR, CHAR_SUBSTITUTE);
    queue_text(OP_PUT_CHAR, CHAR_TAB);
    queue_text(OP_PUT_CHAR, 8'h41);
    queue_text(OP_PUT_CHAR, CHAR_RETURN);
    queue_text(OP_PUT_CHAR, 8'h5A);
    for (int i = 0; i < 8; i++) queue_text(OP_PUT_CHAR, CHAR_NEWLINE);
    queue_text(OP_PUT_CHAR, 8'h61);
    queue_text(OP_RESET_CURSOR, 8'h00);
    queue_text(OP_PUT_CHAR, 8'h30);

    // Random text, mostly printable so lines fill and wrap
    for (int i = 0; i < 380; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) queue_text(OP_RESET_CURSOR, CODE_W'($urandom_range(0, 255)));
      else if (r < 6) queue_text(OP_PUT_CHAR, CHAR_TAB);
      else if (r < 10) queue_text(OP_PUT_CHAR, CHAR_NEWLINE);
      else if (r < 13) queue_text(OP_PUT_CHAR, CHAR_RETURN);
      else if (r < 17) queue_text(OP_PUT_CHAR, CODE_W'($urandom_range(0, 31)));
      else if (r < 22) queue_text(OP_PUT_CHAR, CODE_W'($urandom_range(128, 255)));
      else queue_text(OP_PUT_CHAR, CODE_W'($urandom_range(32, 127)));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all requests taken, all beats seen, then let the back end settle
    while (pending_text.size() > 0 || in_valid_i) @(posedge clk_i);
    while (lcd_beats_due.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d requests: %0d glyphs, %0d cursor resets, %0d line wraps",
             requests_taken, glyphs_drawn, cursor_resets, line_wraps);
    $display("checked %0d command/data beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0 && lcd_beats_due.size() == 0)
      $display("text_cursor_glyph_command_sequencer regression: pass");
    else
      $display("text_cursor_glyph_command_sequencer regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("text_cursor_glyph_command_sequencer regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/tcgcs_pkg.sv
hdl/tcgcs_front.sv
hdl/tcgcs_queue.sv
hdl/tcgcs_back.sv
hdl/text_cursor_glyph_command_sequencer.sv
hdl/tcgcs_checker.sv
tb/tb.sv
